/* hdl/att_pkg.sv */
// Shared types and constants for the allocation tracking table.
// Holds the word layouts, the status and action codes and the control structs.
// Depends on nothing; att_ctrl, att_datapath and the top level import it.
package att_pkg;

    localparam int RECORDS_DEFAULT = 64;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_THREAD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_CPU = 2'd2;

    localparam logic [1:0] FM_ALL = 2'd0;
    localparam logic [1:0] FM_THREAD = 2'd1;
    localparam logic [1:0] FM_CPU = 2'd2;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    localparam logic [2:0] ST_NEW = 3'd0;
    localparam logic [2:0] ST_DUP = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_FILT = 3'd3;
    localparam logic [2:0] ST_FREED = 3'd4;
    localparam logic [2:0] ST_UNKNOWN = 3'd5;
    localparam logic [2:0] ST_IGNORED = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] address;
        logic [31:0] block_size;
        logic [31:0] heap_id;
        logic [31:0] thread_id;
        logic [3:0]  cpu;
        logic [31:0] time_ms;
        logic [5:0]  slot_index;
    } att_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [6:0]  live_blocks;
        logic [37:0] live_bytes;
        logic        rec_valid;
        logic [31:0] rec_address;
        logic [31:0] rec_size;
        logic [31:0] rec_heap;
        logic [31:0] rec_thread;
        logic [31:0] rec_time;
        logic [3:0]  rec_cpu;
    } att_rsp_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] address;
        logic [31:0] block_size;
        logic [31:0] heap_id;
        logic [31:0] thread_id;
        logic [31:0] time_ms;
        logic [3:0]  cpu;
    } att_rec_t;

    typedef struct packed {
        logic take;
        logic cnt_clear;
        logic scan_issue;
        logic read_issue;
        logic wipe_write;
        logic finish;
    } att_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic is_clear;
        logic cnt_last;
    } att_sts_t;

endpackage

/* hdl/att_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module att_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/att_ctrl.sv */
// Sequencing controller for the allocation tracking table.
// Depends on att_pkg for the command and status structs.
module att_ctrl import att_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    input  att_sts_t sts,
    output att_cmd_t cmd
);

    localparam logic [2:0] S_WIPE = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DISPATCH = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       wipe_item_reg, wipe_item_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       out_free;

    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        wipe_item_next = wipe_item_reg;
        cmd = '0;
        case (state_reg)
            S_WIPE:
            begin
                cmd.wipe_write = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = wipe_item_reg ? S_FINISH : S_IDLE;
                    wipe_item_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.take = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.cnt_clear = 1'b1;
                if (sts.need_scan)
                begin
                    state_next = S_SCAN;
                end
                else if (sts.is_clear)
                begin
                    wipe_item_next = 1'b1;
                    state_next = S_WIPE;
                end
                else
                begin
                    cmd.read_issue = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_WIPE;
            wipe_item_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wipe_item_reg <= wipe_item_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

/* hdl/att_datapath.sv */
// Datapath of the allocation tracking table: filter registers, word register,
// slot scan, running totals, record memory and the result register.
// Depends on att_pkg and att_ram.
module att_datapath import att_pkg::*; #(
    parameter int RECORDS = RECORDS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  att_req_t               req,
    output att_rsp_t               rsp,
    input  att_cmd_t               cmd,
    output att_sts_t               sts
);

    localparam int IDX_W = (RECORDS > 1) ? $clog2(RECORDS) : 1;
    localparam int CNT_W = $clog2(RECORDS + 1);
    localparam int REC_W = $bits(att_rec_t);

    logic [1:0]       filter_mode_reg;
    logic [31:0]      filter_thread_reg;
    logic [3:0]       filter_cpu_reg;

    att_req_t         item_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             rd_pend_reg;
    logic [IDX_W-1:0] rd_tag_reg;
    logic             match_found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic [31:0]      match_size_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [CNT_W-1:0] block_total_reg, block_total_next;
    logic [37:0]      byte_total_reg, byte_total_next;
    att_rsp_t         rsp_reg, rsp_next;

    logic             passes;
    logic             alloc_ok;
    logic             match_hit;
    logic             free_hit;
    logic             in_range;
    att_rec_t         entry;
    logic [REC_W-1:0] ram_rdata;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    att_rec_t         ram_wrec;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic             fin_we;
    logic [IDX_W-1:0] fin_idx;
    att_rec_t         fin_rec;

    always_comb
    begin
        case (filter_mode_reg)
            FM_THREAD: passes = (item_reg.thread_id == filter_thread_reg);
            FM_CPU:    passes = (item_reg.cpu == filter_cpu_reg);
            default:   passes = 1'b1;
        endcase
    end

    assign alloc_ok = (item_reg.address != 32'd0) && (item_reg.block_size != 32'd0) && passes;

    assign sts.need_scan = ((item_reg.action == ACT_ALLOC) && alloc_ok)
        || ((item_reg.action == ACT_FREE) && (item_reg.address != 32'd0));
    assign sts.is_clear = (item_reg.action == ACT_CLEAR);
    assign sts.cnt_last = (cnt_reg == CNT_W'(RECORDS - 1));

    assign entry = att_rec_t'(ram_rdata);
    assign match_hit = rd_pend_reg && entry.valid && (entry.address == item_reg.address);
    assign free_hit = rd_pend_reg && !entry.valid;
    assign in_range = (32'(item_reg.slot_index) < 32'(RECORDS));

    always_comb
    begin
        rsp_next = '0;
        fin_we = 1'b0;
        fin_idx = match_idx_reg;
        fin_rec.valid = 1'b1;
        fin_rec.address = item_reg.address;
        fin_rec.block_size = item_reg.block_size;
        fin_rec.heap_id = item_reg.heap_id;
        fin_rec.thread_id = item_reg.thread_id;
        fin_rec.time_ms = item_reg.time_ms;
        fin_rec.cpu = item_reg.cpu;
        block_total_next = block_total_reg;
        byte_total_next = byte_total_reg;
        rsp_next.status = ST_DONE;
        case (item_reg.action)
            ACT_ALLOC:
            begin
                if ((item_reg.address == 32'd0) || (item_reg.block_size == 32'd0))
                begin
                    rsp_next.status = ST_IGNORED;
                end
                else if (!passes)
                begin
                    rsp_next.status = ST_FILT;
                end
                else if (match_found_reg)
                begin
                    rsp_next.status = ST_DUP;
                    rsp_next.slot = 6'(match_idx_reg);
                    fin_we = 1'b1;
                    byte_total_next = byte_total_reg - 38'(match_size_reg)
                        + 38'(item_reg.block_size);
                end
                else if (free_found_reg)
                begin
                    rsp_next.status = ST_NEW;
                    rsp_next.slot = 6'(free_idx_reg);
                    fin_we = 1'b1;
                    fin_idx = free_idx_reg;
                    block_total_next = block_total_reg + CNT_W'(1);
                    byte_total_next = byte_total_reg + 38'(item_reg.block_size);
                end
                else
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            ACT_FREE:
            begin
                if (item_reg.address == 32'd0)
                begin
                    rsp_next.status = ST_IGNORED;
                end
                else if (match_found_reg)
                begin
                    rsp_next.status = ST_FREED;
                    rsp_next.slot = 6'(match_idx_reg);
                    fin_we = 1'b1;
                    fin_rec.valid = 1'b0;
                    block_total_next = block_total_reg - CNT_W'(1);
                    byte_total_next = byte_total_reg - 38'(match_size_reg);
                end
                else
                begin
                    rsp_next.status = ST_UNKNOWN;
                end
            end
            ACT_READ:
            begin
                rsp_next.slot = item_reg.slot_index;
                if (in_range && entry.valid)
                begin
                    rsp_next.rec_valid = 1'b1;
                    rsp_next.rec_address = entry.address;
                    rsp_next.rec_size = entry.block_size;
                    rsp_next.rec_heap = entry.heap_id;
                    rsp_next.rec_thread = entry.thread_id;
                    rsp_next.rec_time = entry.time_ms;
                    rsp_next.rec_cpu = entry.cpu;
                end
            end
            default:
            begin
                block_total_next = '0;
                byte_total_next = '0;
            end
        endcase
        rsp_next.live_blocks = 7'(block_total_next);
        rsp_next.live_bytes = byte_total_next;
    end

    always_comb
    begin
        ram_we = cmd.wipe_write || (cmd.finish && fin_we);
        ram_waddr = cmd.wipe_write ? cnt_reg[IDX_W-1:0] : fin_idx;
        ram_wrec = cmd.wipe_write ? att_rec_t'('0) : fin_rec;
        ram_re = cmd.scan_issue || cmd.read_issue;
        ram_raddr = cmd.scan_issue ? cnt_reg[IDX_W-1:0] : IDX_W'(item_reg.slot_index);
    end

    att_ram #(
        .WIDTH (REC_W),
        .DEPTH (RECORDS)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wrec),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg <= FM_ALL;
            filter_thread_reg <= '0;
            filter_cpu_reg <= '0;
            cnt_reg <= '0;
            rd_pend_reg <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            block_total_reg <= '0;
            byte_total_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_FILTER_MODE:   filter_mode_reg <= cfg_data[1:0];
                    CFG_FILTER_THREAD: filter_thread_reg <= cfg_data;
                    CFG_FILTER_CPU:    filter_cpu_reg <= cfg_data[3:0];
                    default:           filter_mode_reg <= filter_mode_reg;
                endcase
            end
            if (cmd.cnt_clear)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.scan_issue || cmd.wipe_write)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            rd_pend_reg <= cmd.scan_issue;
            if (cmd.cnt_clear)
            begin
                match_found_reg <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (match_hit && !match_found_reg)
                begin
                    match_found_reg <= 1'b1;
                end
                if (free_hit && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.finish)
            begin
                block_total_reg <= block_total_next;
                byte_total_reg <= byte_total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            item_reg <= req;
        end
        rd_tag_reg <= cnt_reg[IDX_W-1:0];
        if (match_hit && !match_found_reg)
        begin
            match_idx_reg <= rd_tag_reg;
            match_size_reg <= entry.block_size;
        end
        if (free_hit && !free_found_reg)
        begin
            free_idx_reg <= rd_tag_reg;
        end
        if (cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

/* hdl/allocation_tracking_table.sv */
// Top level of the allocation tracking table.
// Joins att_ctrl and att_datapath; depends on att_pkg.
//
//   channel   signals                          direction  word
//   req       req_valid, req_ready, req         in         att_req_t
//   rsp       rsp_valid, rsp_ready, rsp         out        att_rsp_t
//   cfg       cfg_write, cfg_index, cfg_data    in         filter registers
//
// Alloc and free words sweep the record memory, one slot a cycle through its
// single read port. Read words and ignored or filtered words skip the sweep;
// a clear instead writes every slot to zero.
// After reset a clearing pass over every slot runs before the first word is taken.
// One word is in work at a time; a finished result waits in the output register,
// and the next word may be accepted while it does.
module allocation_tracking_table import att_pkg::*; #(
    parameter int RECORDS = RECORDS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  att_req_t               req,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output att_rsp_t               rsp,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    att_cmd_t cmd;
    att_sts_t sts;

    att_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    att_datapath #(
        .RECORDS (RECORDS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
